// ===== src/krd_pkg.sv =====
// Shared types and constants of the keyed record deframer.
// Holds the input and result transaction structs, section codes and queue sizing.
// Depends on nothing.
package krd_pkg;

  // One raw byte of the serialized record.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0] decoded_byte;
    logic [1:0] section;
    logic       record_end;
    logic       truncated;
  } out_t;

  // Section codes carried in out_t.section.
  localparam logic [1:0] SecName    = 2'd0;
  localparam logic [1:0] SecAddress = 2'd1;
  localparam logic [1:0] SecFlag    = 2'd2;
  localparam logic [1:0] SecNone    = 2'd3;

  // Bytes of the length header that follow the key.
  localparam logic [15:0] HeaderBytes = 16'd4;

  // Depth of the result queue between the parser and the output stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

endpackage

// ===== src/krd_front.sv =====
// Front part of the deframer: accepts record bytes, tracks the record layout
// and classifies each byte into a result or no result. Uses krd_pkg.
module krd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  krd_pkg::in_t  in_data_i,
  output logic          push_o,
  output krd_pkg::out_t push_data_o
);

  typedef enum logic [2:0] {
    PhKey,
    PhHeader,
    PhName,
    PhAddress,
    PhFlag,
    PhIgnore
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  key_q, key_d;
  logic [15:0] name_len_q, name_len_d;
  logic [15:0] addr_len_q, addr_len_d;
  logic [15:0] left_q, left_d;

  logic [15:0] left_dec;
  logic [15:0] hdr_left;
  logic [7:0]  byte_v;
  logic        last_v;

  assign byte_v   = in_data_i.data_byte;
  assign last_v   = in_data_i.last_byte;
  assign left_dec = left_q - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    key_d       = key_q;
    name_len_d  = name_len_q;
    addr_len_d  = addr_len_q;
    left_d      = left_q;
    push_o      = 1'b0;
    push_data_o = '0;
    hdr_left    = left_q;

    if (accept_i) begin
      case (phase_q)
        PhIgnore: begin
          if (last_v) begin
            phase_d = PhKey;
          end
        end

        PhFlag: begin
          push_o                   = 1'b1;
          push_data_o.decoded_byte = {7'd0, (byte_v != 8'd0)};
          push_data_o.section      = krd_pkg::SecFlag;
          push_data_o.record_end   = 1'b1;
          phase_d                  = last_v ? PhKey : PhIgnore;
          left_d                   = '0;
        end

        PhName, PhAddress: begin
          push_o = 1'b1;
          if (phase_q == PhName) begin
            push_data_o.decoded_byte = byte_v - key_q;
            push_data_o.section      = krd_pkg::SecName;
          end else begin
            push_data_o.decoded_byte = byte_v + key_q;
            push_data_o.section      = krd_pkg::SecAddress;
          end
          if (last_v) begin
            push_data_o.record_end = 1'b1;
            push_data_o.truncated  = 1'b1;
            phase_d                = PhKey;
            left_d                 = '0;
          end else begin
            left_d = left_dec;
            if (left_dec == 16'd0) begin
              if (phase_q == PhName && addr_len_q != 16'd0) begin
                phase_d = PhAddress;
                left_d  = addr_len_q;
              end else begin
                phase_d = PhFlag;
                left_d  = '0;
              end
            end
          end
        end

        PhHeader: begin
          if (left_q == 16'd0 || left_q > krd_pkg::HeaderBytes) begin
            hdr_left = krd_pkg::HeaderBytes;
          end
          if (hdr_left > 16'd2) begin
            name_len_d = {name_len_q[7:0], byte_v};
          end else begin
            addr_len_d = {addr_len_q[7:0], byte_v};
          end
          left_d = hdr_left - 16'd1;
          if (left_d == 16'd0) begin
            if (name_len_d != 16'd0) begin
              phase_d = PhName;
              left_d  = name_len_d;
            end else if (addr_len_d != 16'd0) begin
              phase_d = PhAddress;
              left_d  = addr_len_d;
            end else begin
              phase_d = PhFlag;
              left_d  = '0;
            end
          end
        end

        default: begin
          // Expecting a key byte; this also covers codes that mean nothing.
          key_d      = byte_v;
          name_len_d = '0;
          addr_len_d = '0;
          phase_d    = PhHeader;
          left_d     = krd_pkg::HeaderBytes;
        end
      endcase

      // A buffer that ends inside the key or header reports truncation alone.
      if (last_v && (phase_q != PhIgnore) && (phase_q != PhFlag) &&
          (phase_q != PhName) && (phase_q != PhAddress)) begin
        push_o                   = 1'b1;
        push_data_o.decoded_byte = '0;
        push_data_o.section      = krd_pkg::SecNone;
        push_data_o.record_end   = 1'b1;
        push_data_o.truncated    = 1'b1;
        phase_d                  = PhKey;
        left_d                   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhKey;
      key_q      <= '0;
      name_len_q <= '0;
      addr_len_q <= '0;
      left_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      key_q      <= key_d;
      name_len_q <= name_len_d;
      addr_len_q <= addr_len_d;
      left_q     <= left_d;
    end
  end

endmodule

// ===== src/krd_queue.sv =====
// Short result queue that decouples the parser from the output stage.
// Register-based FIFO sized by krd_pkg::QueueDepth. Uses krd_pkg.
module krd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  krd_pkg::out_t push_data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output logic          full_o,
  output krd_pkg::out_t pop_data_o
);

  krd_pkg::out_t                    mem_q [krd_pkg::QueueDepth];
  logic [krd_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [krd_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [krd_pkg::QueueCntW-1:0]    count_q, count_d;

  localparam logic [krd_pkg::QueuePtrW-1:0] LastPtr =
    krd_pkg::QueuePtrW'(krd_pkg::QueueDepth - 1);
  localparam logic [krd_pkg::QueueCntW-1:0] FullCount =
    krd_pkg::QueueCntW'(krd_pkg::QueueDepth);

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == FullCount);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/krd_back.sv =====
// Back part of the deframer: moves results from the queue into the output
// register and holds them until the consumer takes them. Uses krd_pkg.
module krd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  krd_pkg::out_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output krd_pkg::out_t out_data_o
);

  logic          valid_q, valid_d;
  krd_pkg::out_t data_q;
  logic          load;

  // The output register can take a new result when empty or being drained.
  assign load    = !valid_q || !out_stall_i;
  assign q_pop_o = load && !q_empty_i;
  assign valid_d = load ? !q_empty_i : valid_q;

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule

// ===== src/keyed_record_deframer_core.sv =====
// Top level of the keyed record deframer.
// Connects the parsing front end, the result queue and the output stage.
// Uses krd_pkg, krd_front, krd_queue and krd_back.
//
//   Channel   Direction   Handshake               Payload
//   -------   ---------   ---------------------   ------------------------------
//   input     in          in_valid_i / in_stall_o  in_data_i  (krd_pkg::in_t)
//   output    out         out_valid_o / out_stall_i out_data_o (krd_pkg::out_t)
//
// One byte transaction is accepted per clock while the result queue has room.
// A byte that produces a result is written into the queue at the edge that accepts
// it, and the output register then loads it from the queue once it can take a new
// result.
// Reset clears the parser to expect a key byte and empties queue and output.
// A stalled output fills the two-entry queue; only then is the input stalled.
//
// A record is a key byte, a big-endian 16-bit name length, a big-endian 16-bit
// address length, the name bytes, the address bytes and a flag byte. Name bytes
// are decoded by subtracting the key, address bytes by adding it, both modulo
// 256. The flag byte yields 1 when nonzero. Key and length bytes yield nothing
// unless the buffer ends on one of them, in which case a single truncation
// report (section code for no data) closes the record. A buffer ending on a
// name or address byte marks that byte's result as the truncated record end.
// Bytes after the flag are dropped until the buffer ends.
module keyed_record_deframer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  krd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output krd_pkg::out_t out_data_o
);

  logic          accept;
  logic          push;
  krd_pkg::out_t push_data;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  krd_pkg::out_t q_data;

  // Stall only while the queue is full, so every accepted byte has a slot
  // for the at most one result it can cause.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  krd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  krd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .full_o      (q_full),
    .pop_data_o  (q_data)
  );

  krd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== verif/tb_keyed_record_deframer_core.sv =====
// Self-checking testbench for keyed_record_deframer_core.
// Drives byte transactions, predicts every result and checks it on the output side.
// Depends on krd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb_keyed_record_deframer_core;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 8;
  // Header bytes 4 and 3 carry the name length, 2 and 1 the address length.
  localparam logic [15:0] NameHeaderLow = 16'd2;
  // Random records keep their bodies short; longer declared lengths get cut.
  localparam int unsigned MaxBody = 24;

  typedef enum logic [2:0] {
    PhKey, PhHeader, PhName, PhAddress, PhFlag, PhTrail
  } parse_phase_e;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  krd_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  krd_pkg::out_t out_data_o;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned parsed_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Predicted parser state.
  parse_phase_e  exp_phase = PhKey;
  logic [7:0]    exp_key = '0;
  logic [15:0]   exp_name_len = '0;
  logic [15:0]   exp_addr_len = '0;
  logic [15:0]   exp_left = '0;
  krd_pkg::out_t pending_results[$];

  keyed_record_deframer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("keyed_record_deframer_core verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic krd_pkg::in_t byte_item(input logic [7:0] data, input logic last);
    byte_item.data_byte = data;
    byte_item.last_byte = last;
  endfunction

  // Move to the first section after 'from' that declares any bytes.
  function automatic void enter_section_after(input parse_phase_e from);
    if (from < PhName && exp_name_len != 16'd0) begin
      exp_phase = PhName;
      exp_left  = exp_name_len;
    end else if (from < PhAddress && exp_addr_len != 16'd0) begin
      exp_phase = PhAddress;
      exp_left  = exp_addr_len;
    end else begin
      exp_phase = PhFlag;
      exp_left  = 16'd0;
    end
  endfunction

  // Advance the predicted parser by one byte and queue the result it causes.
  // Returns 0 only for trailing bytes, which the block drops.
  function automatic bit decode_byte(input krd_pkg::in_t item);
    krd_pkg::out_t res;
    logic [15:0]   left;
    res = '0;
    if (exp_phase == PhTrail) begin
      if (item.last_byte) exp_phase = PhKey;
      return 1'b0;
    end
    if (exp_phase == PhFlag) begin
      res.decoded_byte = (item.data_byte != 8'd0) ? 8'd1 : 8'd0;
      res.section      = krd_pkg::SecFlag;
      res.record_end   = 1'b1;
      exp_phase = item.last_byte ? PhKey : PhTrail;
      exp_left  = 16'd0;
      pending_results.push_back(res);
      return 1'b1;
    end
    if (exp_phase == PhName || exp_phase == PhAddress) begin
      if (exp_phase == PhName) begin
        res.decoded_byte = item.data_byte - exp_key;
        res.section      = krd_pkg::SecName;
      end else begin
        res.decoded_byte = item.data_byte + exp_key;
        res.section      = krd_pkg::SecAddress;
      end
      if (item.last_byte) begin
        // The buffer ran out inside a section: this byte closes the record.
        res.record_end = 1'b1;
        res.truncated  = 1'b1;
        exp_phase = PhKey;
        exp_left  = 16'd0;
      end else begin
        exp_left = exp_left - 16'd1;
        if (exp_left == 16'd0) enter_section_after(exp_phase);
      end
      pending_results.push_back(res);
      return 1'b1;
    end
    if (exp_phase == PhHeader) begin
      left = (exp_left == 16'd0 || exp_left > krd_pkg::HeaderBytes) ?
             krd_pkg::HeaderBytes : exp_left;
      if (left > NameHeaderLow) exp_name_len = {exp_name_len[7:0], item.data_byte};
      else exp_addr_len = {exp_addr_len[7:0], item.data_byte};
      left     = left - 16'd1;
      exp_left = left;
      if (left == 16'd0) enter_section_after(PhHeader);
    end else begin
      exp_key      = item.data_byte;
      exp_name_len = 16'd0;
      exp_addr_len = 16'd0;
      exp_phase    = PhHeader;
      exp_left     = krd_pkg::HeaderBytes;
    end
    if (item.last_byte) begin
      // Buffer ended on a key or header byte: a data-less truncation report.
      res.section    = krd_pkg::SecNone;
      res.record_end = 1'b1;
      res.truncated  = 1'b1;
      pending_results.push_back(res);
      exp_phase = PhKey;
      exp_left  = 16'd0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // Result checker: every accepted output transaction against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    krd_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_data_o.decoded_byte, 8'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.decoded_byte !== want.decoded_byte)
          report_mismatch("decoded_byte", out_data_o.decoded_byte, want.decoded_byte);
        if (out_data_o.section !== want.section)
          report_mismatch("section", 8'(out_data_o.section), 8'(want.section));
        if (out_data_o.record_end !== want.record_end)
          report_mismatch("record_end", 8'(out_data_o.record_end), 8'(want.record_end));
        if (out_data_o.truncated !== want.truncated)
          report_mismatch("truncated", 8'(out_data_o.truncated), 8'(want.truncated));
      end
    end
  end

  // Offer one byte transaction, after a random gap, and hold it until accepted.
  task automatic send_byte(input krd_pkg::in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_byte(item)) parsed_count++;
  endtask

  // Send a byte sequence with last_byte set on its final byte only.
  task automatic send_buffer(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(byte_item(seq[i], i == seq.size() - 1));
  endtask

  // Hold the input off until every predicted result has been delivered.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // A complete record, a flag without last_byte, and a trailing byte that ends it.
  task automatic test_full_record();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h80, 8'hFF};
    send_buffer(seq);
  endtask

  // Both lengths zero: the flag follows the header directly; a zero flag gives 0.
  task automatic test_empty_sections();
    logic [7:0] seq[$];
    seq = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_buffer(seq);
  endtask

  // Buffers that end on a key byte, on a header byte and on a name byte.
  task automatic test_truncation();
    logic [7:0] seq[$];
    seq = '{8'h3C};
    send_buffer(seq);
    seq = '{8'hA5, 8'h00};
    send_buffer(seq);
    seq = '{8'h5A, 8'h00, 8'h01, 8'h00, 8'h00, 8'h59};
    send_buffer(seq);
  endtask

  // One well-formed record with random content; some declare long sections and
  // some are cut short at a random byte.
  task automatic send_random_record();
    krd_pkg::in_t rec[$];
    logic [15:0]  name_len;
    logic [15:0]  addr_len;
    int unsigned  body;
    int unsigned  cut;
    bit           cut_short;
    name_len = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    addr_len = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    cut_short = (int'(name_len) + int'(addr_len) > MaxBody);
    body = cut_short ? $urandom_range(0, MaxBody) : int'(name_len) + int'(addr_len);
    rec.push_back(byte_item(8'($urandom), 1'b0));
    rec.push_back(byte_item(name_len[15:8], 1'b0));
    rec.push_back(byte_item(name_len[7:0], 1'b0));
    rec.push_back(byte_item(addr_len[15:8], 1'b0));
    rec.push_back(byte_item(addr_len[7:0], 1'b0));
    repeat (body) rec.push_back(byte_item(8'($urandom), 1'b0));
    if (!cut_short)
      rec.push_back(byte_item(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'b0));
    if (cut_short || $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, rec.size() - 1);
      while (rec.size() > cut + 1) void'(rec.pop_back());
    end else begin
      repeat ($urandom_range(0, 3)) rec.push_back(byte_item(8'($urandom), 1'b0));
    end
    rec[rec.size() - 1].last_byte = 1'b1;
    foreach (rec[i]) send_byte(rec[i]);
  endtask

  // Unstructured bytes with scattered buffer ends, closed by a final last_byte.
  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_byte(byte_item(8'($urandom), $urandom_range(0, 5) == 0));
    send_byte(byte_item(8'($urandom), 1'b1));
  endtask

  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct,
                                     input int unsigned count);
    int unsigned start;
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    start = parsed_count;
    while (parsed_count - start < count) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_record();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_record();
    test_empty_sections();
    test_truncation();
    wait_for_results();

    test_random_traffic(0, 0, 390);
    test_random_traffic(76, 0, 390);
    test_random_traffic(0, 76, 390);
    test_random_traffic(8, 8, 390);

    if (error_count == 0) begin
      $display("keyed_record_deframer_core verification clean");
    end else begin
      $display("keyed_record_deframer_core verification failed");
    end
    $finish;
  end

endmodule
